>>> sv/lattice_gradient_noise_2d_core_assert.svh
// Assertion macros used by the noise core RTL.
`ifndef LATTICE_GRADIENT_NOISE_2D_CORE_ASSERT_SVH
`define LATTICE_GRADIENT_NOISE_2D_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define LGN2_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lgn2 assertion failed");
// Next-cycle implication, disabled while reset is high.
`define LGN2_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lgn2 assertion failed");
`else
`define LGN2_ASSERT_IMP(label, clk, rst, ante, cons)
`define LGN2_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/lgn2_pkg.sv
// Shared constants, types and control structs of the lattice noise core.
package lgn2_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int GRID_BITS  = 7;
   localparam int IDX_W      = 2 * GRID_BITS;
   localparam int BANK_AW    = IDX_W - 2;
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int NOISE_W    = FRAC_BITS + 3;
   localparam int DIFF_W     = NOISE_W + 1;
   localparam int FADE_W     = FRAC_BITS + 1;
   localparam int ONE        = 1 << FRAC_BITS;

   // quintic fade 6t^5 - 15t^4 + 10t^3
   localparam int FADE_A = 6;
   localparam int FADE_B = 15;
   localparam int FADE_C = 10;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } cmd_type;

   typedef logic [FRAC_BITS-1:0]      frac_type;
   typedef logic [FADE_W-1:0]         fade_type;
   typedef logic signed [NOISE_W-1:0] noise_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic [GRID_BITS-1:0]      grid_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_index;
      logic             wr_sign;
      logic             rd_en;
      grid_type         row;
      grid_type         col;
   } tbl_req_type;

   typedef struct packed {
      logic sq;
      logic cube;
      logic fade;
   } fade_en_type;

   typedef struct packed {
      logic mul;
      logic add;
   } lerp_en_type;

endpackage

>>> sv/lgn2_sign_table.sv
// Sign table split into four parity banks so all four corners are read in the same cycle.
module lgn2_sign_table (
   input  logic                  clock,
   input  lgn2_pkg::tbl_req_type req,
   output logic [3:0]            corner_sign
);

   localparam int GB = lgn2_pkg::GRID_BITS;
   localparam int AW = lgn2_pkg::BANK_AW;
   localparam int IW = lgn2_pkg::IDX_W;

   logic [1:0]         wr_bank;
   logic [AW-1:0]      wr_addr;
   lgn2_pkg::grid_type row_next;
   lgn2_pkg::grid_type col_next;
   logic               px_ff;
   logic               py_ff;
   wire  [3:0]         bank_rd;

   // bank = {row parity, column parity}
   assign wr_bank  = {req.wr_index[GB], req.wr_index[0]};
   assign wr_addr  = {req.wr_index[IW-1:GB+1], req.wr_index[GB-1:1]};
   assign row_next = req.row + GB'(1);
   assign col_next = req.col + GB'(1);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic RP = 1'((b >> 1) & 1);
      localparam logic CP = 1'(b & 1);

      logic               bank_mem [lgn2_pkg::BANK_DEPTH];
      logic               rd_ff;
      lgn2_pkg::grid_type rsel;
      lgn2_pkg::grid_type csel;
      logic [AW-1:0]      rd_addr;

      assign rsel    = (req.row[0] == RP) ? req.row : row_next;
      assign csel    = (req.col[0] == CP) ? req.col : col_next;
      assign rd_addr = {rsel[GB-1:1], csel[GB-1:1]};

      always_ff @(posedge clock) begin
         if (req.wr_en && (wr_bank == 2'(b))) begin
            bank_mem[wr_addr] <= req.wr_sign;
         end
         if (req.rd_en) begin
            rd_ff <= bank_mem[rd_addr];
         end
      end

      assign bank_rd[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         px_ff <= req.row[0];
         py_ff <= req.col[0];
      end
   end

   // corner index {dy, dx}: un-swap the banks by the base corner parity
   always_comb begin
      corner_sign[0] = bank_rd[{px_ff, py_ff}];
      corner_sign[1] = bank_rd[{~px_ff, py_ff}];
      corner_sign[2] = bank_rd[{px_ff, ~py_ff}];
      corner_sign[3] = bank_rd[{~px_ff, ~py_ff}];
   end

endmodule

>>> sv/lgn2_fade.sv
// Three-stage quintic fade curve on a fraction.
module lgn2_fade (
   input  logic                  clock,
   input  lgn2_pkg::fade_en_type en,
   input  lgn2_pkg::frac_type    t,
   output lgn2_pkg::fade_type    f
);

   localparam int FB   = lgn2_pkg::FRAC_BITS;
   localparam int SW   = 2 * FB;
   localparam int PW   = FB + 5;
   localparam int QW   = FB + 4;
   localparam int MW   = FB + QW;
   localparam int QOUT = MW - FB;
   localparam int FW   = lgn2_pkg::FADE_W;

   lgn2_pkg::frac_type t_ff;
   lgn2_pkg::frac_type t2_ff;
   lgn2_pkg::frac_type t3_ff;
   logic [QW-1:0]      p_ff;
   lgn2_pkg::fade_type f_ff;

   logic [SW-1:0]      sq;
   logic [SW-1:0]      cube;
   logic [PW-1:0]      poly;
   logic [MW-1:0]      prod;
   logic [QOUT-1:0]    q;
   lgn2_pkg::fade_type f_in;

   assign sq   = SW'(t) * SW'(t);
   assign cube = SW'(t2_ff) * SW'(t_ff);
   // p = 6*t2 - 15*t + 10*one never goes negative
   assign poly = PW'(t2_ff) * PW'(lgn2_pkg::FADE_A)
               + PW'(lgn2_pkg::FADE_C * lgn2_pkg::ONE)
               - PW'(t_ff) * PW'(lgn2_pkg::FADE_B);
   assign prod = MW'(t3_ff) * MW'(p_ff);
   assign q    = prod[MW-1:FB];
   assign f_in = (q > QOUT'(lgn2_pkg::ONE)) ? FW'(lgn2_pkg::ONE) : q[FW-1:0];

   always_ff @(posedge clock) begin
      if (en.sq) begin
         t_ff  <= t;
         t2_ff <= sq[SW-1:FB];
      end
      if (en.cube) begin
         t3_ff <= cube[SW-1:FB];
         p_ff  <= poly[QW-1:0];
      end
      if (en.fade) begin
         f_ff <= f_in;
      end
   end

   assign f = f_ff;

endmodule

>>> sv/lgn2_lerp.sv
// Two-stage linear blend y = a + floor(f * d / one).
module lgn2_lerp (
   input  logic                  clock,
   input  lgn2_pkg::lerp_en_type en,
   input  lgn2_pkg::noise_type   a,
   input  lgn2_pkg::diff_type    d,
   input  lgn2_pkg::fade_type    f,
   output lgn2_pkg::noise_type   y
);

   localparam int FB  = lgn2_pkg::FRAC_BITS;
   localparam int NW  = lgn2_pkg::NOISE_W;
   localparam int PRW = lgn2_pkg::FADE_W + 1 + lgn2_pkg::DIFF_W;

   logic signed [PRW-1:0] prod_in;
   logic signed [PRW-1:0] prod_ff;
   lgn2_pkg::noise_type   a_ff;
   lgn2_pkg::noise_type   y_in;
   lgn2_pkg::noise_type   y_ff;

   assign prod_in = PRW'(signed'({1'b0, f})) * PRW'(d);
   // arithmetic shift floors toward minus infinity
   assign y_in    = a_ff + NW'(prod_ff >>> FB);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (en.add) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

>>> sv/lattice_gradient_noise_2d_core.sv
// Throughput: one item per cycle unless rsp_stall backs up the pipeline;
// the four corner signs come from four parity banks of the sign table,
// one read port each, so no item waits.
// A write item updates the table as it leaves stage 1 and yields no result.
// Reset (synchronous) clears the stage valid bits only; the sign table is
// undefined until written and gets no clearing pass.
`include "lattice_gradient_noise_2d_core_assert.svh"

module lattice_gradient_noise_2d_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [lgn2_pkg::IDX_W-1:0]          req_table_index,
   input  logic                                req_table_sign,
   input  logic signed [lgn2_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [lgn2_pkg::COORD_W-1:0] req_y_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lgn2_pkg::NOISE_W-1:0] rsp_noise_value
);

   localparam int NS = 9;
   localparam int FB = lgn2_pkg::FRAC_BITS;
   localparam int GB = lgn2_pkg::GRID_BITS;
   localparam int NW = lgn2_pkg::NOISE_W;
   localparam lgn2_pkg::noise_type ONE_S     = NW'(lgn2_pkg::ONE);
   localparam lgn2_pkg::noise_type TWO_S     = NW'(2 * lgn2_pkg::ONE);
   localparam lgn2_pkg::fade_type  FADE_ONE  = lgn2_pkg::FADE_W'(lgn2_pkg::ONE);

   // Stage valid bits and per-stage advance. A stage loads when it is empty
   // or when the stage after it loads, so bubbles collapse under a stall.
   logic [NS:1] v_ff;
   logic [NS:1] v_in;
   logic [NS:1] rdy;

   // Stage 1: input transfer
   lgn2_pkg::cmd_type                s1_cmd_ff;
   logic [lgn2_pkg::IDX_W-1:0]       s1_index_ff;
   logic                             s1_sign_ff;
   logic signed [lgn2_pkg::COORD_W-1:0] s1_x_ff;
   logic signed [lgn2_pkg::COORD_W-1:0] s1_y_ff;

   // Stage 2: table read, fx + fy
   lgn2_pkg::tbl_req_type tbl_req;
   logic [3:0]            corner_sign;
   lgn2_pkg::noise_type   s2_sum_in;
   lgn2_pkg::noise_type   s2_sum_ff;

   // Stage 3: signed corner contributions
   lgn2_pkg::noise_type   s3_corner_in [4];
   lgn2_pkg::noise_type   s3_corner_ff [4];

   // Stage 4: blend operands along x
   lgn2_pkg::noise_type   s4_c0_ff;
   lgn2_pkg::noise_type   s4_c2_ff;
   lgn2_pkg::diff_type    s4_d01_ff;
   lgn2_pkg::diff_type    s4_d23_ff;
   lgn2_pkg::fade_type    ux;
   lgn2_pkg::fade_type    uy;

   // Stages 5 to 7: x blends, then y blend operands
   lgn2_pkg::fade_type    s5_uy_ff;
   lgn2_pkg::fade_type    s6_uy_ff;
   lgn2_pkg::fade_type    s7_uy_ff;
   lgn2_pkg::noise_type   lx0;
   lgn2_pkg::noise_type   lx1;
   lgn2_pkg::noise_type   s7_l0_ff;
   lgn2_pkg::diff_type    s7_dy_ff;

   // ---------------------------------------------------------------
   // Handshake and valid pipeline
   // ---------------------------------------------------------------
   always_comb begin
      rdy[NS] = !v_ff[NS] || !rsp_stall;
      for (int k = NS - 1; k >= 1; k--) begin
         rdy[k] = !v_ff[k] || rdy[k + 1];
      end
   end

   always_comb begin
      v_in[1] = req_valid;
      // drop write items here: they are done once the table is updated
      v_in[2] = v_ff[1] && (s1_cmd_ff == lgn2_pkg::CMD_EVAL);
      for (int k = 3; k <= NS; k++) begin
         v_in[k] = v_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req_stall = !rdy[1];
   assign rsp_valid = v_ff[NS];

   // ---------------------------------------------------------------
   // Stage 1: capture the transfer
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_cmd_ff   <= lgn2_pkg::cmd_type'(req_command);
         s1_index_ff <= req_table_index;
         s1_sign_ff  <= req_table_sign;
         s1_x_ff     <= req_x_coord;
         s1_y_ff     <= req_y_coord;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: table access. Writes and reads both issue from stage 1, so a
   // write always lands before any later item reads the table.
   // The low GRID_BITS of the integer part are the wrapped lattice index,
   // which gives the non-negative modulo for negative coordinates too.
   // ---------------------------------------------------------------
   always_comb begin
      tbl_req.wr_en    = v_ff[1] && (s1_cmd_ff == lgn2_pkg::CMD_WRITE) && rdy[2];
      tbl_req.wr_index = s1_index_ff;
      tbl_req.wr_sign  = s1_sign_ff;
      tbl_req.rd_en    = rdy[2];
      tbl_req.row      = s1_x_ff[FB+GB-1:FB];
      tbl_req.col      = s1_y_ff[FB+GB-1:FB];
   end

   lgn2_sign_table u_table (
      .clock       (clock),
      .req         (tbl_req),
      .corner_sign (corner_sign)
   );

   assign s2_sum_in = signed'(NW'(s1_x_ff[FB-1:0]) + NW'(s1_y_ff[FB-1:0]));

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_sum_ff <= s2_sum_in;
      end
   end

   // Fade curves run alongside stages 2 to 4.
   lgn2_fade u_fade_x (
      .clock (clock),
      .en    ('{sq: rdy[2], cube: rdy[3], fade: rdy[4]}),
      .t     (s1_x_ff[FB-1:0]),
      .f     (ux)
   );

   lgn2_fade u_fade_y (
      .clock (clock),
      .en    ('{sq: rdy[2], cube: rdy[3], fade: rdy[4]}),
      .t     (s1_y_ff[FB-1:0]),
      .f     (uy)
   );

   // ---------------------------------------------------------------
   // Stage 3: corner k = {dy, dx} contributes sign * (fx - dx + fy - dy)
   // ---------------------------------------------------------------
   always_comb begin
      s3_corner_in[0] = corner_sign[0] ? -s2_sum_ff : s2_sum_ff;
      s3_corner_in[1] = corner_sign[1] ? (ONE_S - s2_sum_ff) : (s2_sum_ff - ONE_S);
      s3_corner_in[2] = corner_sign[2] ? (ONE_S - s2_sum_ff) : (s2_sum_ff - ONE_S);
      s3_corner_in[3] = corner_sign[3] ? (TWO_S - s2_sum_ff) : (s2_sum_ff - TWO_S);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int k = 0; k < 4; k++) begin
            s3_corner_ff[k] <= s3_corner_in[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: differences for the x blends
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_c0_ff  <= s3_corner_ff[0];
         s4_c2_ff  <= s3_corner_ff[2];
         s4_d01_ff <= lgn2_pkg::diff_type'(s3_corner_ff[1])
                    - lgn2_pkg::diff_type'(s3_corner_ff[0]);
         s4_d23_ff <= lgn2_pkg::diff_type'(s3_corner_ff[3])
                    - lgn2_pkg::diff_type'(s3_corner_ff[2]);
      end
   end

   // ---------------------------------------------------------------
   // Stages 5 and 6: blend along x for both rows
   // ---------------------------------------------------------------
   lgn2_lerp u_lerp_x0 (
      .clock (clock),
      .en    ('{mul: rdy[5], add: rdy[6]}),
      .a     (s4_c0_ff),
      .d     (s4_d01_ff),
      .f     (ux),
      .y     (lx0)
   );

   lgn2_lerp u_lerp_x1 (
      .clock (clock),
      .en    ('{mul: rdy[5], add: rdy[6]}),
      .a     (s4_c2_ff),
      .d     (s4_d23_ff),
      .f     (ux),
      .y     (lx1)
   );

   // carry the y fade alongside the x blends
   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_uy_ff <= uy;
      end
      if (rdy[6]) begin
         s6_uy_ff <= s5_uy_ff;
      end
      if (rdy[7]) begin
         s7_uy_ff <= s6_uy_ff;
         s7_l0_ff <= lx0;
         s7_dy_ff <= lgn2_pkg::diff_type'(lx1) - lgn2_pkg::diff_type'(lx0);
      end
   end

   // ---------------------------------------------------------------
   // Stages 8 and 9: blend along y; stage 9 is the output register.
   // Blends stay between their end points, so the result needs no clamp.
   // ---------------------------------------------------------------
   lgn2_lerp u_lerp_y (
      .clock (clock),
      .en    ('{mul: rdy[8], add: rdy[9]}),
      .a     (s7_l0_ff),
      .d     (s7_dy_ff),
      .f     (s7_uy_ff),
      .y     (rsp_noise_value)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `LGN2_ASSERT_NXT(a_write_retires, clock, reset, v_ff[1] && (s1_cmd_ff == lgn2_pkg::CMD_WRITE) && rdy[2], !v_ff[2])
   `LGN2_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, v_ff[NS] && rsp_stall)
   `LGN2_ASSERT_IMP(a_fade_bounded, clock, reset, v_ff[4], (ux <= FADE_ONE) && (uy <= FADE_ONE))
   `LGN2_ASSERT_IMP(a_result_range, clock, reset, rsp_valid, (rsp_noise_value <= TWO_S) && (rsp_noise_value >= -TWO_S))

endmodule
